// File: hw/rtl/duty_slew_limiter_unit_assert.svh
// ----------------------------------------------------------------------------
// duty slew limiter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DUTY_SLEW_LIMITER_UNIT_ASSERT_SVH
`define DUTY_SLEW_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// types, constants and clamp helpers of the duty slew limiter
// ----------------------------------------------------------------------------
`default_nettype none

package dsl_pkg;

  localparam int DUTY_W     = 7;
  localparam int VALUE_W    = 8;
  localparam int SINCE_W    = 16;
  localparam int TICKS_W    = 10;
  localparam int PROD_W     = 17;
  localparam int QUOT_W     = 35;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 7'd100;
  localparam logic [DUTY_W-1:0]  DUTY_AT_RESET = 7'd50;
  localparam logic [SINCE_W-1:0] SINCE_SAT     = 16'hFFFF;
  localparam int ROUND_HALF  = 50;
  localparam int RECIP_100   = 167773;
  localparam int RECIP_SHIFT = 24;

  localparam logic [DUTY_W-1:0]  RST_FLOOR    = 7'd0;
  localparam logic [DUTY_W-1:0]  RST_CEILING  = 7'd100;
  localparam logic [DUTY_W-1:0]  RST_STEP     = 7'd1;
  localparam logic [SINCE_W-1:0] RST_INTERVAL = 16'd100;
  localparam logic [TICKS_W-1:0] RST_FULL     = 10'd255;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_TARGET  = 3'd2,
    CMD_NUDGE   = 3'd3,
    CMD_RECLAMP = 3'd4
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR    = 3'd0,
    REG_CEILING  = 3'd1,
    REG_STEP     = 3'd2,
    REG_INTERVAL = 3'd3,
    REG_FULL     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceiling;
    logic [DUTY_W-1:0]  slew_step;
    logic [SINCE_W-1:0] slew_interval;
    logic [TICKS_W-1:0] full_scale_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] target;
  } duty_pair_t;

  function automatic logic [DUTY_W-1:0] cap100(input logic [DUTY_W-1:0] v);
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

  // floor first, then ceiling, so the ceiling wins
  function automatic logic [DUTY_W-1:0] clamp_limits(input logic [VALUE_W-1:0] v,
                                                     input logic [DUTY_W-1:0] floor_raw,
                                                     input logic [DUTY_W-1:0] ceil_raw);
    logic [DUTY_W-1:0]  lo;
    logic [DUTY_W-1:0]  hi;
    logic [VALUE_W-1:0] t;
    lo = cap100(floor_raw);
    hi = cap100(ceil_raw);
    t  = v;
    if (t < {1'b0, lo}) t = {1'b0, lo};
    if (t > {1'b0, hi}) t = {1'b0, hi};
    return t[DUTY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dsl_cfg_regs.sv
// ----------------------------------------------------------------------------
// dsl_cfg_regs
// configuration register bank with plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_cfg_regs
  import dsl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_floor       <= RST_FLOOR;
      cfg_r.duty_ceiling     <= RST_CEILING;
      cfg_r.slew_step        <= RST_STEP;
      cfg_r.slew_interval    <= RST_INTERVAL;
      cfg_r.full_scale_ticks <= RST_FULL;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FLOOR:    cfg_r.duty_floor       <= cfg_wdata[DUTY_W-1:0];
        REG_CEILING:  cfg_r.duty_ceiling     <= cfg_wdata[DUTY_W-1:0];
        REG_STEP:     cfg_r.slew_step        <= cfg_wdata[DUTY_W-1:0];
        REG_INTERVAL: cfg_r.slew_interval    <= cfg_wdata[SINCE_W-1:0];
        REG_FULL:     cfg_r.full_scale_ticks <= cfg_wdata[TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/dsl_core.sv
// ----------------------------------------------------------------------------
// dsl_core
// duty, target and ramp timer state, one command per cycle while no held result blocks it
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_core
  import dsl_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  cfg_t                           cfg,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  wire logic [2:0]                cmd_code,
  input  wire logic [VALUE_W-1:0]        cmd_value,
  input  wire logic signed [VALUE_W-1:0] cmd_nudge,
  input  wire logic                      cmd_manual,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output duty_pair_t                     res
);

  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [DUTY_W-1:0]  target_r, target_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic               valid_r;
  duty_pair_t         res_r;
  logic               fire;

  logic [SINCE_W-1:0]      since_inc;
  logic                    ramp_up;
  logic [DUTY_W-1:0]       gap;
  logic [DUTY_W-1:0]       stepped;
  logic signed [VALUE_W:0] nudge_sum;
  logic [VALUE_W-1:0]      nudge_sat;

  assign cmd_ready = !valid_r || res_ready;
  assign fire      = cmd_valid && cmd_ready;

  always_comb begin
    since_inc = (since_r == SINCE_SAT) ? since_r : since_r + 16'd1;
    ramp_up   = target_r > duty_r;
    gap       = ramp_up ? (target_r - duty_r) : (duty_r - target_r);
    if (cfg.slew_step >= gap) begin
      stepped = target_r;
    end else if (ramp_up) begin
      stepped = duty_r + cfg.slew_step;
    end else begin
      stepped = duty_r - cfg.slew_step;
    end

    nudge_sum = $signed({2'b00, duty_r}) + $signed({cmd_nudge[VALUE_W-1], cmd_nudge});
    if (nudge_sum < 0) begin
      nudge_sat = '0;
    end else if (nudge_sum > $signed({2'b00, DUTY_MAX})) begin
      nudge_sat = {1'b0, DUTY_MAX};
    end else begin
      nudge_sat = nudge_sum[VALUE_W-1:0];
    end

    duty_nxt   = duty_r;
    target_nxt = target_r;
    since_nxt  = since_r;
    unique case (command_t'(cmd_code))
      CMD_TICK: begin
        if (!cmd_manual) begin
          target_nxt = duty_r;
          since_nxt  = '0;
        end else if (target_r != duty_r && since_inc >= cfg.slew_interval) begin
          since_nxt = '0;
          duty_nxt  = clamp_limits({1'b0, stepped}, cfg.duty_floor, cfg.duty_ceiling);
        end else begin
          since_nxt = since_inc;
        end
      end
      CMD_SET: begin
        duty_nxt = clamp_limits(cmd_value, cfg.duty_floor, cfg.duty_ceiling);
      end
      CMD_TARGET: begin
        target_nxt = clamp_limits(cmd_value, cfg.duty_floor, cfg.duty_ceiling);
        since_nxt  = cfg.slew_interval;
      end
      CMD_NUDGE: begin
        duty_nxt   = clamp_limits(nudge_sat, cfg.duty_floor, cfg.duty_ceiling);
        target_nxt = duty_nxt;
        since_nxt  = '0;
      end
      CMD_RECLAMP: begin
        duty_nxt = clamp_limits({1'b0, duty_r}, cfg.duty_floor, cfg.duty_ceiling);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r   <= DUTY_AT_RESET;
      target_r <= DUTY_AT_RESET;
      since_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        duty_r   <= duty_nxt;
        target_r <= target_nxt;
        since_r  <= since_nxt;
      end
      if (cmd_ready) valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.duty   <= duty_nxt;
      res_r.target <= target_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// File: hw/rtl/dsl_scale.sv
// ----------------------------------------------------------------------------
// dsl_scale
// compare tick scaling: product stage, then divide by one hundred
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_scale
  import dsl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [TICKS_W-1:0]   full_scale,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  duty_pair_t                in_pair,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DUTY_W-1:0]         out_duty,
  output logic [TICKS_W-1:0]        out_ticks,
  output logic [DUTY_W-1:0]         out_target
);

  logic               prod_valid_r;
  logic [PROD_W-1:0]  prod_r;
  duty_pair_t         prod_pair_r;
  logic               res_valid_r;
  logic [TICKS_W-1:0] ticks_r;
  duty_pair_t         res_pair_r;

  logic               res_ready;
  logic               prod_ready;
  logic [PROD_W-1:0]  prod_nxt;
  logic [QUOT_W-1:0]  quot_full;

  assign res_ready  = !res_valid_r || out_ready;
  assign prod_ready = !prod_valid_r || res_ready;
  assign in_ready   = prod_ready;

  // (duty * full_scale + 50) then multiply by 2^24/100 to divide
  assign prod_nxt  = PROD_W'(cap100(in_pair.duty)) * PROD_W'(full_scale)
                   + PROD_W'(ROUND_HALF);
  assign quot_full = QUOT_W'(prod_r) * QUOT_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) prod_valid_r <= in_valid;
      if (res_ready)  res_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      prod_r      <= prod_nxt;
      prod_pair_r <= in_pair;
    end
    if (res_ready && prod_valid_r) begin
      ticks_r    <= quot_full[RECIP_SHIFT +: TICKS_W];
      res_pair_r <= prod_pair_r;
    end
  end

  assign out_valid  = res_valid_r;
  assign out_duty   = res_pair_r.duty;
  assign out_target = res_pair_r.target;
  assign out_ticks  = ticks_r;

endmodule

`default_nettype wire

// File: hw/rtl/duty_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// duty_slew_limiter_unit
// duty keeper with floor/ceiling clamp, manual slew ramp and tick scaling
// ----------------------------------------------------------------------------
// in_* carries one command request: in_tuser holds the command code, in_tdata
// the duty value, the signed nudge step and the manual mode flag.
// out_* returns one result per command: duty, compare ticks and ramp target.
// cfg_* writes the limit, step, interval and full scale registers; write them
// only while no request is in flight.
// the input register loads at the accepting edge; then state update, duty times
// full scale product and reciprocal divide by one hundred take one register each.
// throughput is one request per cycle while out_tready is high, set by the state update.
// reset restores the register defaults, sets duty and target to 50 and
// empties the pipeline.
// when out_tready is low the stages keep filling; in_tready drops once all
// four stages hold a request, and no request is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module duty_slew_limiter_unit
  import dsl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // duty_value, nudge_step, manual_mode
  input  wire logic [2:0]            in_tuser,   // command
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,  // duty, compare_ticks, ramp_target
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                        cfg;
  logic                        in_valid_r;
  logic [2:0]                  code_r;
  logic [VALUE_W-1:0]          value_r;
  logic signed [VALUE_W-1:0]   nudge_r;
  logic                        manual_r;
  logic                        core_ready;
  logic                        core_valid;
  duty_pair_t                  core_pair;
  logic                        scale_ready;
  logic [DUTY_W-1:0]           res_duty;
  logic [TICKS_W-1:0]          res_ticks;
  logic [DUTY_W-1:0]           res_target;

  dsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_tready = !in_valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      code_r   <= in_tuser;
      value_r  <= in_tdata[7:0];
      nudge_r  <= $signed(in_tdata[15:8]);
      manual_r <= in_tdata[16];
    end
  end

  dsl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (in_valid_r),
    .cmd_ready  (core_ready),
    .cmd_code   (code_r),
    .cmd_value  (value_r),
    .cmd_nudge  (nudge_r),
    .cmd_manual (manual_r),
    .res_valid  (core_valid),
    .res_ready  (scale_ready),
    .res        (core_pair)
  );

  dsl_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .full_scale (cfg.full_scale_ticks),
    .in_valid   (core_valid),
    .in_ready   (scale_ready),
    .in_pair    (core_pair),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_duty   (res_duty),
    .out_ticks  (res_ticks),
    .out_target (res_target)
  );

  assign out_tdata = {res_target, res_ticks, res_duty};

endmodule

`default_nettype wire

// File: hw/rtl/dsl_checker.sv
// ----------------------------------------------------------------------------
// dsl_checker
// port-level checks of the duty slew limiter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "duty_slew_limiter_unit_assert.svh"

module dsl_checker
  import dsl_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [23:0]           out_tdata
);

  logic [DUTY_W-1:0]  chk_duty;
  logic [TICKS_W-1:0] chk_ticks;
  logic [DUTY_W-1:0]  chk_target;

  assign chk_duty   = out_tdata[6:0];
  assign chk_ticks  = out_tdata[16:7];
  assign chk_target = out_tdata[23:17];

  `DSL_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")
  `DSL_ASSERT_IMP(a_duty_range, clk, rst_n, out_tvalid, chk_duty <= DUTY_MAX,
    "duty above one hundred")
  `DSL_ASSERT_IMP(a_target_range, clk, rst_n, out_tvalid, chk_target <= DUTY_MAX,
    "ramp target above one hundred")
  `DSL_ASSERT_IMP(a_zero_ticks, clk, rst_n, out_tvalid && chk_duty == '0,
    chk_ticks == '0, "compare ticks nonzero at zero duty")

endmodule

bind duty_slew_limiter_unit dsl_checker u_dsl_checker (.*);

`default_nettype wire

// File: tb/sv/duty_slew_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty slew limiter checker
// watches the command, result and register ports, keeps its own copy of the
// duty, target and millisecond state, predicts one report per command and
// compares every returned report field by field in order
// ----------------------------------------------------------------------------
module duty_slew_checker
  import dsl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [23:0]           in_tdata,
  input  wire logic [2:0]            in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [23:0]           out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         outstanding,
  output int                         fail_count
);

  typedef struct packed {
    logic [DUTY_W-1:0]  target;
    logic [TICKS_W-1:0] ticks;
    logic [DUTY_W-1:0]  duty;
  } duty_report_t;

  cfg_t         settings;
  int           duty_pct;
  int           target_pct;
  int           since_ms;
  duty_report_t duty_report_q[$];

  function automatic int within_limits(input int v);
    int lo;
    int hi;
    lo = (settings.duty_floor > DUTY_MAX) ? 100 : int'(settings.duty_floor);
    hi = (settings.duty_ceiling > DUTY_MAX) ? 100 : int'(settings.duty_ceiling);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic duty_report_t advance_duty(input logic [2:0] cmd,
                                                input logic [7:0] dval,
                                                input logic signed [7:0] nstep,
                                                input logic manual);
    int           level;
    duty_report_t r;
    case (cmd)
      CMD_TICK: begin
        if (since_ms < int'(SINCE_SAT)) since_ms = since_ms + 1;
        if (!manual) begin
          target_pct = duty_pct;
          since_ms   = 0;
        end else if (target_pct != duty_pct && since_ms >= int'(settings.slew_interval)) begin
          since_ms = 0;
          if (target_pct > duty_pct) begin
            level = duty_pct + int'(settings.slew_step);
            if (level > target_pct) level = target_pct;
          end else begin
            level = duty_pct - int'(settings.slew_step);
            if (level < target_pct) level = target_pct;
          end
          duty_pct = within_limits(level);
        end
      end
      CMD_SET: begin
        duty_pct = within_limits(int'(dval));
      end
      CMD_TARGET: begin
        target_pct = within_limits(int'(dval));
        since_ms   = int'(settings.slew_interval);
      end
      CMD_NUDGE: begin
        level = duty_pct + int'(nstep);
        if (level < 0) level = 0;
        if (level > 100) level = 100;
        duty_pct   = within_limits(level);
        target_pct = duty_pct;
        since_ms   = 0;
      end
      CMD_RECLAMP: begin
        duty_pct = within_limits(duty_pct);
      end
      default: begin
      end
    endcase
    r.duty   = DUTY_W'(duty_pct);
    r.ticks  = TICKS_W'((duty_pct * int'(settings.full_scale_ticks) + ROUND_HALF) / 100);
    r.target = DUTY_W'(target_pct);
    return r;
  endfunction

  task automatic count_failure(input string what);
    if (fail_count < 10) $display("%0t: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    duty_report_t got;
    duty_report_t want;
    if (!rst_n) begin
      settings = '{duty_floor: RST_FLOOR, duty_ceiling: RST_CEILING, slew_step: RST_STEP,
                   slew_interval: RST_INTERVAL, full_scale_ticks: RST_FULL};
      duty_pct   = int'(DUTY_AT_RESET);
      target_pct = int'(DUTY_AT_RESET);
      since_ms   = 0;
      duty_report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FLOOR:    settings.duty_floor       = cfg_wdata[DUTY_W-1:0];
          REG_CEILING:  settings.duty_ceiling     = cfg_wdata[DUTY_W-1:0];
          REG_STEP:     settings.slew_step        = cfg_wdata[DUTY_W-1:0];
          REG_INTERVAL: settings.slew_interval    = cfg_wdata[SINCE_W-1:0];
          REG_FULL:     settings.full_scale_ticks = cfg_wdata[TICKS_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        duty_report_q.push_back(advance_duty(in_tuser, in_tdata[7:0], in_tdata[15:8],
                                             in_tdata[16]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (duty_report_q.size() == 0) begin
          count_failure($sformatf("unexpected report %h", out_tdata));
        end else begin
          want = duty_report_q.pop_front();
          if (got.duty !== want.duty)
            count_failure($sformatf("duty: expected %0d, got %0d", want.duty, got.duty));
          if (got.ticks !== want.ticks)
            count_failure($sformatf("compare ticks: expected %0d, got %0d",
                                    want.ticks, got.ticks));
          if (got.target !== want.target)
            count_failure($sformatf("ramp target: expected %0d, got %0d",
                                    want.target, got.target));
        end
      end
    end
    outstanding <= duty_report_q.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty slew limiter testbench
// drives directed and random command requests and register settings into the
// limiter with random idle bursts on both sides, lets the checker predict and
// compare, and closes with a stretch without idling that walks the
// millisecond counter into saturation through a target request
// ----------------------------------------------------------------------------
module tb;
  import dsl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // duty_value, nudge_step, manual_mode, zero fill
  logic [2:0]            in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;  // duty, compare_ticks, ramp_target
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int outstanding;
  int fail_count;
  int cycle_count;
  int sent;
  bit idle_en = 1'b1;

  always #5 clk = ~clk;

  duty_slew_limiter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  duty_slew_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [2:0] code, input int dval, input int nstep,
                              input logic manual);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {7'd0, manual, 8'(nstep), 8'(dval)};
    sent = sent + 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic set_limits(input int floor_v, input int ceil_v, input int step_v,
                            input int span_v, input int full_v);
    drain;
    write_reg(REG_FLOOR, floor_v);
    write_reg(REG_CEILING, ceil_v);
    write_reg(REG_STEP, step_v);
    write_reg(REG_INTERVAL, span_v);
    write_reg(REG_FULL, full_v);
    cfg_we <= 1'b0;
  endtask

  task automatic random_limits;
    int floor_v;
    int ceil_v;
    int step_v;
    int span_v;
    int full_v;
    floor_v = $urandom_range(0, 50);
    ceil_v  = $urandom_range(50, 100);
    step_v  = $urandom_range(1, 25);
    span_v  = $urandom_range(0, 6);
    full_v  = $urandom_range(0, 1023);
    case ($urandom_range(0, 9))
      0: floor_v = $urandom_range(95, 127);
      1: ceil_v = $urandom_range(0, 40);
      2: ceil_v = $urandom_range(100, 127);
      3: step_v = ($urandom_range(0, 1) == 0) ? 0 : 100;
      4: span_v = ($urandom_range(0, 1) == 0) ? 100 : 65535;
      5: full_v = ($urandom_range(0, 1) == 0) ? 0 : 1023;
      default: begin
      end
    endcase
    set_limits(floor_v, ceil_v, step_v, span_v, full_v);
  endtask

  task automatic random_burst(input int count);
    int left;
    int ticks;
    logic [2:0] code;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        // ramp: new target followed by mostly manual ticks
        send_request(CMD_TARGET, $urandom_range(0, 120), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
        ticks = $urandom_range(2, 16);
        left  = left - ticks - 1;
        repeat (ticks) begin
          case ($urandom_range(0, 19))
            0: send_request(CMD_SET, $urandom_range(0, 110), $urandom_range(0, 255), 1'b1);
            1: send_request(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
            2: send_request(CMD_RECLAMP, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
            default:
              send_request(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
          endcase
        end
      end else begin
        if ($urandom_range(0, 15) == 0) code = CMD_UNUSED_LO + 3'($urandom_range(0, 2));
        else code = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0)
          send_request(code, $urandom_range(0, 255), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)));
        else
          send_request(code, $urandom_range(0, 100), int'($urandom_range(0, 200)) - 100,
                       1'($urandom_range(0, 1)));
        left = left - 1;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FLOOR;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // default limits
    send_request(CMD_TICK, 0, 0, 1'b0);
    send_request(CMD_SET, 255, 0, 1'b0);
    send_request(CMD_SET, 0, 0, 1'b0);
    send_request(CMD_TARGET, 255, 0, 1'b0);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_NUDGE, 0, 127, 1'b0);
    send_request(CMD_NUDGE, 0, -128, 1'b0);
    send_request(CMD_NUDGE, 0, 100, 1'b0);
    send_request(CMD_NUDGE, 0, -100, 1'b0);
    send_request(CMD_NUDGE, 255, 0, 1'b1);
    send_request(CMD_RECLAMP, 0, 0, 1'b0);
    send_request(CMD_UNUSED_LO, 255, 255, 1'b1);
    send_request(CMD_UNUSED_LO + 3'd1, 255, -128, 1'b0);
    send_request(CMD_UNUSED_LO + 3'd2, 0, 0, 1'b1);

    // floor above ceiling
    set_limits(30, 20, 0, 0, 0);
    send_request(CMD_SET, 0, 0, 1'b0);
    send_request(CMD_RECLAMP, 0, 0, 1'b0);
    send_request(CMD_TARGET, 90, 0, 1'b0);

    // limits above one hundred
    set_limits(127, 127, 0, 0, 1023);
    send_request(CMD_SET, 5, 0, 1'b0);

    // zero step and zero interval
    set_limits(0, 100, 0, 0, 0);
    send_request(CMD_SET, 40, 0, 1'b0);
    send_request(CMD_TARGET, 60, 0, 1'b0);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);

    set_limits(0, 100, 100, 0, 1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TARGET, 0, 0, 1'b0);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b0);

    while (sent < 1000) begin
      random_limits();
      idle_en = ($urandom_range(0, 3) != 0);
      random_burst($urandom_range(40, 110));
    end

    // no idling from here on
    idle_en = 1'b0;
    random_limits();
    random_burst(80);

    // millisecond counter saturation: a target request loads the full interval
    set_limits(0, 100, 7, 65535, 1023);
    send_request(CMD_TARGET, 40, 0, 1'b1);
    send_request(CMD_SET, 40, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_SET, 100, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);
    send_request(CMD_TICK, 0, 0, 1'b1);

    drain;
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
